// ===== design/sbs_pkg.sv =====
package sbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    // Register index as decoded from paddr[2].
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [9:0]               entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
    } sbs_in_t;

    typedef struct packed {
        logic       found;
        logic [9:0] found_index;
    } sbs_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE
    } sbs_state_t;

    typedef struct packed {
        logic write;
        logic load;
        logic probe;
        logic step;
        logic report_hit;
        logic report_miss;
    } sbs_cmd_t;

    typedef struct packed {
        logic empty;
        logic equal;
    } sbs_status_t;

endpackage

// ===== design/sorted_table_binary_search_top.sv =====
// Write beat: taken while idle, no result; the next beat may start in the following cycle.
// Search beat: each probe is a PROBE state (registered RAM read), then a COMPARE state, and a
// final PROBE state detects an empty range; at most 11 probes over 1024 entries.
// The result is shown for one cycle on done, in the first cycle with busy low; it cannot be held off.
// Reset (rst_n, asynchronous, active low) clears entries_in_use and the controller; the
// table RAM is not cleared.
module sorted_table_binary_search_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sbs_pkg::sbs_in_t             request,
    output logic                        done,
    output sbs_pkg::sbs_out_t            result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sbs_pkg::*;

    logic [COUNT_W-1:0] entries_reg;
    sbs_cmd_t           cmd;
    sbs_status_t        status;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[2] == REG_ENTRIES_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_write)
        begin
            entries_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ENTRIES_IN_USE: prdata = {{(32 - COUNT_W){1'b0}}, entries_reg};
            default:            prdata = '0;
        endcase
    end

    sbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (request.op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sbs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (request),
        .entries_in_use (entries_reg),
        .cmd            (cmd),
        .status         (status),
        .done           (done),
        .result         (result)
    );

endmodule

// ===== design/sbs_ram.sv =====
module sbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sbs_ctrl.sv =====
module sbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                op,
    input  sbs_pkg::sbs_status_t status,
    output sbs_pkg::sbs_cmd_t    cmd,
    output logic                busy
);
    import sbs_pkg::*;

    sbs_state_t state_reg;
    sbs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (op == OP_SEARCH)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_PROBE:
            begin
                if (status.empty)
                begin
                    cmd.report_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                if (status.equal)
                begin
                    cmd.report_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sbs_datapath.sv =====
module sbs_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbs_pkg::sbs_in_t              request,
    input  logic [sbs_pkg::COUNT_W-1:0]  entries_in_use,
    input  sbs_pkg::sbs_cmd_t             cmd,
    output sbs_pkg::sbs_status_t          status,
    output logic                         done,
    output sbs_pkg::sbs_out_t             result
);
    import sbs_pkg::*;

    logic signed [DATA_W-1:0] key_reg;
    logic [COUNT_W-1:0]       lo_reg;
    logic [COUNT_W-1:0]       hi_reg;   // one past the last candidate
    logic [ADDR_W-1:0]        mid_reg;
    logic                     done_reg;
    sbs_out_t                 result_reg;

    logic [COUNT_W:0]   sum;
    logic [ADDR_W-1:0]  mid;
    logic [COUNT_W-1:0] count_sat;
    logic [DATA_W-1:0]  rd_data;
    logic               greater;

    assign count_sat = (entries_in_use > COUNT_W'(TABLE_DEPTH)) ?
                       COUNT_W'(TABLE_DEPTH) : entries_in_use;

    // With the upper bound held exclusive, the inclusive midpoint is (lo + hi - 1) / 2.
    assign sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (COUNT_W + 1)'(1);
    assign mid = sum[ADDR_W:1];

    sbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (request.entry_index[ADDR_W-1:0]),
        .wdata (request.entry_value),
        .raddr (mid),
        .rdata (rd_data)
    );

    assign greater      = $signed(rd_data) > key_reg;
    assign status.empty = !(lo_reg < hi_reg);
    assign status.equal = $signed(rd_data) == key_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= request.search_key;
            lo_reg  <= '0;
            hi_reg  <= count_sat;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid;
        end
        if (cmd.step)
        begin
            if (greater)
            begin
                hi_reg <= {1'b0, mid_reg};
            end
            else
            begin
                lo_reg <= {1'b0, mid_reg} + COUNT_W'(1);
            end
        end
        if (cmd.report_hit)
        begin
            result_reg.found       <= 1'b1;
            result_reg.found_index <= 10'(mid_reg);
        end
        else if (cmd.report_miss)
        begin
            result_reg.found       <= 1'b0;
            result_reg.found_index <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report_hit | cmd.report_miss;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== tb/tb_sorted_table_binary_search_top.sv =====
module tb_sorted_table_binary_search_top;
    import sbs_pkg::*;

    localparam int MOST_NEGATIVE = 32'sh8000_0000;
    localparam int MOST_POSITIVE = 32'sh7fff_ffff;
    localparam int ITEM_TARGET   = 1600;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    sbs_in_t            request = '0;
    logic               done;
    sbs_out_t           result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    sorted_table_binary_search_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: the table as the block should hold it and the search span.
    logic signed [31:0] mirror_entries [TABLE_DEPTH];
    logic [10:0]        span_setting = '0;
    sbs_out_t           expected_lookups [$];

    // Stimulus side: beats waiting to be driven and the table as the stimulus leaves it.
    sbs_in_t            item_queue [$];
    int                 shadow_entries [TABLE_DEPTH];
    int                 items_queued = 0;
    bit                 gaps_on = 1'b0;
    int                 idle_left = 0;
    int                 failures = 0;
    sbs_out_t           awaited;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic sbs_out_t lookup_outcome(input logic signed [31:0] key);
        int       lo;
        int       hi;
        int       mid;
        bit       hit;
        sbs_out_t outcome;
        outcome = '0;
        hit = 1'b0;
        lo = 0;
        hi = ((int'(span_setting) > TABLE_DEPTH) ? TABLE_DEPTH : int'(span_setting)) - 1;
        while (!hit && lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (mirror_entries[mid] == key)
            begin
                hit = 1'b1;
                outcome.found = 1'b1;
                outcome.found_index = 10'(mid);
            end
            else if (mirror_entries[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return outcome;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // A beat is taken at an edge where start is high and busy is low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (request.op == OP_WRITE)
                    mirror_entries[request.entry_index] = request.entry_value;
                else
                    expected_lookups = {expected_lookups, lookup_outcome(request.search_key)};
                idle_left = gaps_on ? pick_gap() : 0;
            end
            if (!(start && busy))
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (item_queue.size() != 0)
                begin
                    request <= item_queue.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual found=%0b index=%0d",
                         $time, result.found, result.found_index);
                failures++;
            end
            else
            begin
                awaited = expected_lookups.pop_front();
                if (result.found !== awaited.found)
                begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, awaited.found, result.found);
                    failures++;
                end
                if (result.found_index !== awaited.found_index)
                begin
                    $display("%0t: found_index mismatch: expected %0d, actual %0d",
                             $time, awaited.found_index, result.found_index);
                    failures++;
                end
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (item_queue.size() != 0 || start || busy || expected_lookups.size() != 0);
        // A write beat gives no result, so wait further here for it to finish.
        repeat (4) @(negedge clk);
    endtask

    task automatic set_entries_in_use(input logic [31:0] word);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ENTRIES_IN_USE, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        span_setting = word[10:0];
    endtask

    task automatic queue_write(input int idx, input int value);
        sbs_in_t beat;
        beat = '0;
        beat.op = OP_WRITE;
        beat.entry_index = 10'(idx);
        beat.entry_value = value;
        beat.search_key = $urandom;
        item_queue = {item_queue, beat};
        shadow_entries[idx] = value;
        items_queued++;
    endtask

    task automatic queue_search(input int key);
        sbs_in_t beat;
        beat = '0;
        beat.op = OP_SEARCH;
        beat.entry_index = 10'($urandom);
        beat.entry_value = $urandom;
        beat.search_key = key;
        item_queue = {item_queue, beat};
        items_queued++;
    endtask

    // Fills entries 0..n-1 with a non-decreasing run; a narrow stride gives many duplicates.
    task automatic load_sorted_prefix(input int n);
        longint cursor;
        longint stride;
        bit     narrow;
        narrow = ($urandom_range(0, 2) == 0);
        stride = narrow ? 64'sd3 : (64'sd1 <<< 32) / (n + 1);
        cursor = narrow ? longint'($signed($urandom)) / 2 : longint'(MOST_NEGATIVE);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 || narrow || $urandom_range(0, 1))
                cursor += longint'($urandom) % (2 * stride + 1);
            if (cursor > MOST_POSITIVE)
                cursor = MOST_POSITIVE;
            queue_write(i, int'(cursor));
        end
    endtask

    function automatic int pick_key(input int n);
        int r;
        r = $urandom_range(0, 99);
        if (n == 0 || r < 15)
            return $urandom;
        if (r < 60)
            return shadow_entries[$urandom_range(0, n - 1)];
        if (r < 85)
            return shadow_entries[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        return $urandom_range(0, 1) ? MOST_NEGATIVE : MOST_POSITIVE;
    endfunction

    initial
    begin
        int          phase_no;
        int          span;
        int          lookups;
        int          r;
        logic [10:0] setting;
        logic [31:0] word;

        @(posedge rst_n);
        wait_idle();

        // Empty table: every search misses.
        set_entries_in_use(32'd0);
        queue_search(0);
        queue_search(MOST_NEGATIVE);
        queue_write(0, MOST_NEGATIVE);
        queue_write(1, -1);
        queue_write(2, 0);
        queue_write(3, 5);
        queue_write(4, MOST_POSITIVE);
        queue_write(TABLE_DEPTH - 1, $urandom);
        queue_write(TABLE_DEPTH / 2, $urandom);

        wait_idle();
        set_entries_in_use(32'd1);
        queue_search(MOST_NEGATIVE);
        queue_search(MOST_POSITIVE);

        wait_idle();
        set_entries_in_use(32'd5);
        queue_search(MOST_NEGATIVE);
        queue_search(-1);
        queue_search(0);
        queue_search(5);
        queue_search(MOST_POSITIVE);
        queue_search(-2);
        queue_search(6);
        queue_search(1);

        phase_no = 0;
        while (items_queued < ITEM_TARGET)
        begin
            wait_idle();
            case (phase_no)
                0, 1: setting = 11'($urandom_range(2, 40));
                2: setting = 11'(TABLE_DEPTH);
                3: setting = 11'h7ff;
                4: setting = 11'(TABLE_DEPTH - 1);
                5: setting = 11'(TABLE_DEPTH + 1);
                default:
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        setting = '0;
                    else if (r < 75)
                        setting = 11'($urandom_range(1, 64));
                    else
                        setting = 11'($urandom_range(65, 2047));
                end
            endcase
            span = (int'(setting) > TABLE_DEPTH) ? TABLE_DEPTH : int'(setting);
            gaps_on = ($urandom_range(0, 9) < 7);
            word = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
            word[10:0] = setting;
            set_entries_in_use(word);

            // Until the full fill every searched entry must be written in this phase.
            if (phase_no <= 2 || (span <= 64 && $urandom_range(0, 1)))
                load_sorted_prefix(span);

            lookups = $urandom_range(10, 40);
            for (int i = 0; i < lookups; i++)
            begin
                if ($urandom_range(0, 99) < 6)
                    queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
                else
                    queue_search(pick_key(span));
            end
            phase_no++;
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (failures == 0 && expected_lookups.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
